### sv/alf_pkg.sv
// ----------------------------------------------------------------------------
// alf_pkg
// Shared types and constants for the adaptive LIF neuron update block.
// ----------------------------------------------------------------------------
`default_nettype none

package alf_pkg;

  localparam int unsigned NEURONS_DEF = 1024;
  localparam int unsigned DT_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MEMBRANE_DECAY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTATION_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMEOSTASIS_DECAY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_LEVEL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPTATION_STEP   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HOMEOSTASIS_STEP  = 3'd6;

  localparam logic [15:0] MEMBRANE_DECAY_RST    = 16'd64880;
  localparam logic [15:0] ADAPTATION_DECAY_RST  = 16'd65208;
  localparam logic [15:0] HOMEOSTASIS_DECAY_RST = 16'd65470;

  typedef enum logic [1:0] {
    CLS_DELIVER,
    CLS_INIT,
    CLS_IGNORE
  } cls_e;

  typedef struct packed {
    cls_e               cls;
    logic [9:0]         neuron;
    logic [31:0]        tick_time;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [15:0]        membrane_decay;
    logic [15:0]        adaptation_decay;
    logic [15:0]        homeostasis_decay;
    logic [15:0]        refractory_ticks;
    logic signed [31:0] reset_level;
    logic signed [31:0] adaptation_step;
    logic [30:0]        homeostasis_step;
  } cfg_t;

endpackage

`default_nettype wire

### sv/alf_if.sv
// ----------------------------------------------------------------------------
// alf_if
// Valid/ready channels for neuron items and update results.
// ----------------------------------------------------------------------------
`default_nettype none

interface alf_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [9:0]         neuron;
  logic [31:0]        tick_time;
  logic signed [31:0] value;

  modport source (output valid, kind, neuron, tick_time, value, input ready);
  modport sink   (input valid, kind, neuron, tick_time, value, output ready);
endinterface

interface alf_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         neuron_out;
  logic               spiked;
  logic               refractory_hold;
  logic               time_error;
  logic signed [31:0] potential_after;
  logic [15:0]        spike_total;

  modport source (output valid, neuron_out, spiked, refractory_hold, time_error,
                  potential_after, spike_total, input ready);
  modport sink   (input valid, neuron_out, spiked, refractory_hold, time_error,
                  potential_after, spike_total, output ready);
endinterface

`default_nettype wire

### sv/alf_ram.sv
// ----------------------------------------------------------------------------
// alf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

### sv/alf_front.sv
// ----------------------------------------------------------------------------
// alf_front
// Accepts items, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_front import alf_pkg::*; #(
  parameter int unsigned NEURONS = NEURONS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alf_in_if.sink     in_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  wire logic  q_pop_i
);

  localparam logic [16:0] NLIM = 17'(NEURONS);

  item_t      entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  item_t      cls_item;
  logic       push, pop;

  always_comb begin
    cls_item.neuron    = in_i.neuron;
    cls_item.tick_time = in_i.tick_time;
    cls_item.value     = in_i.value;
    if ({7'd0, in_i.neuron} >= NLIM) begin
      cls_item.cls = CLS_IGNORE;
    end else if (in_i.kind) begin
      cls_item.cls = CLS_INIT;
    end else begin
      cls_item.cls = CLS_DELIVER;
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cls_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

### sv/alf_back.sv
// ----------------------------------------------------------------------------
// alf_back
// Executes one queued item: state read, decay powers, update, write, result.
// ----------------------------------------------------------------------------
`default_nettype none

module alf_back import alf_pkg::*; #(
  parameter int unsigned NEURONS = NEURONS_DEF,
  parameter int unsigned DT_BITS = DT_BITS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  q_valid_i,
  input  wire item_t q_item_i,
  output logic       q_pop_o,
  alf_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(NEURONS);
  localparam logic [32:0] MAXDT = (33'd1 << DT_BITS) - 33'd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_POW  = 3'd2;
  localparam logic [2:0] S_SCL  = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  typedef struct packed {
    logic signed [31:0] potential;
    logic signed [31:0] thr_base;
    logic signed [31:0] adaptation;
    logic signed [31:0] homeo_bias;
    logic [31:0]        last_update_time;
    logic [31:0]        refractory_end;
    logic [15:0]        spike_counter;
  } row_t;

  typedef struct packed {
    logic [9:0]         neuron_out;
    logic               spiked;
    logic               refractory_hold;
    logic               time_error;
    logic signed [31:0] potential_after;
    logic [15:0]        spike_total;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if ((v[33:31] == 3'b000) || (v[33:31] == 3'b111)) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // sign * ((|v| * p + 0.5) >> 16)
  function automatic logic signed [31:0] scale(input logic signed [31:0] v,
                                               input logic [16:0] p);
    logic [31:0] mag;
    logic [48:0] prod;
    logic [32:0] m;
    mag  = v[31] ? (~v + 32'd1) : v;
    prod = 49'(mag) * 49'(p) + 49'd32768;
    m    = prod[48:16];
    return v[31] ? (~m[31:0] + 32'd1) : m[31:0];
  endfunction

  logic [2:0]         state_q, state_d;
  item_t              item_q, item_d;
  row_t               row_q, row_d, rdata, wrow;
  logic [DT_BITS-1:0] dt_q, dt_d;
  logic [16:0]        pr_q [3];
  logic [16:0]        pr_d [3];
  logic [15:0]        pb_q [3];
  logic [15:0]        pb_d [3];
  logic [15:0]        factor [3];
  logic signed [31:0] dpot_q, dpot_d, dada_q, dada_d, dbias_q, dbias_d;
  result_t            pend_q, pend_d, res_q, res_d;
  logic               res_valid_q, res_valid_d;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [31:0]        dt_full;
  logic [32:0]        mulr [3];
  logic [32:0]        sqr [3];

  // eval path
  logic signed [33:0] pot_sum, thr, ada_sum, bias_sum;
  logic signed [31:0] pot_sat, pot_new;
  logic               hold, spike;
  logic [32:0]        refr_sum;
  logic [31:0]        refr_new;
  logic [15:0]        cnt_new;

  alf_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NEURONS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wrow),
    .raddr_i (AW'(q_item_i.neuron)),
    .rdata_o (rdata)
  );

  assign factor[0] = cfg_i.membrane_decay;
  assign factor[1] = cfg_i.adaptation_decay;
  assign factor[2] = cfg_i.homeostasis_decay;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mulr[i] = 33'(pr_q[i]) * 33'(pb_q[i]) + 33'd32768;
      sqr[i]  = 33'(pb_q[i]) * 33'(pb_q[i]) + 33'd32768;
    end
  end

  assign dt_full = item_q.tick_time - rdata.last_update_time;

  always_comb begin
    pot_sum  = 34'(dpot_q) + 34'(item_q.value);
    pot_sat  = sat32(pot_sum);
    thr      = 34'(row_q.thr_base) + 34'(dada_q) + 34'(dbias_q);
    hold     = item_q.tick_time < row_q.refractory_end;
    spike    = !hold && (34'(pot_sat) >= thr);
    ada_sum  = 34'(dada_q) + 34'(cfg_i.adaptation_step);
    bias_sum = 34'(dbias_q) + 34'({1'b0, cfg_i.homeostasis_step});
    refr_sum = 33'(item_q.tick_time) + 33'(cfg_i.refractory_ticks);
    refr_new = refr_sum[32] ? 32'hffff_ffff : refr_sum[31:0];
    cnt_new  = (row_q.spike_counter != 16'hffff) ? row_q.spike_counter + 16'd1
                                                 : row_q.spike_counter;
    pot_new  = (hold || spike) ? cfg_i.reset_level : pot_sat;
  end

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    row_d       = row_q;
    dt_d        = dt_q;
    pr_d        = pr_q;
    pb_d        = pb_q;
    dpot_d      = dpot_q;
    dada_d      = dada_q;
    dbias_d     = dbias_q;
    pend_d      = pend_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    q_pop_o     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = AW'(item_q.neuron);
    wrow        = row_q;

    if (res_valid_q && out_o.ready) res_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          pend_d  = '0;
          pend_d.neuron_out = q_item_i.neuron;
          unique case (q_item_i.cls)
            CLS_INIT: begin
              ram_we    = 1'b1;
              ram_waddr = AW'(q_item_i.neuron);
              wrow.potential        = cfg_i.reset_level;
              wrow.thr_base         = q_item_i.value;
              wrow.adaptation       = '0;
              wrow.homeo_bias       = '0;
              wrow.last_update_time = q_item_i.tick_time;
              wrow.refractory_end   = q_item_i.tick_time;
              wrow.spike_counter    = '0;
              pend_d.potential_after = cfg_i.reset_level;
              state_d = S_FIN;
            end
            CLS_DELIVER: state_d = S_RD;
            default:     state_d = S_FIN;
          endcase
        end
      end
      S_RD: begin
        row_d = rdata;
        if (item_q.tick_time < rdata.last_update_time) begin
          pend_d.time_error      = 1'b1;
          pend_d.potential_after = rdata.potential;
          pend_d.spike_total     = rdata.spike_counter;
          state_d = S_FIN;
        end else begin
          dt_d = ({1'b0, dt_full} > MAXDT) ? MAXDT[DT_BITS-1:0] : dt_full[DT_BITS-1:0];
          for (int i = 0; i < 3; i++) begin
            pr_d[i] = 17'h10000;
            pb_d[i] = factor[i];
          end
          state_d = S_POW;
        end
      end
      S_POW: begin
        // one exponent bit per cycle, stops once no set bits remain
        if (dt_q == '0) begin
          state_d = S_SCL;
        end else begin
          dt_d = dt_q >> 1;
          for (int i = 0; i < 3; i++) begin
            if (dt_q[0]) pr_d[i] = mulr[i][32:16];
            pb_d[i] = sqr[i][31:16];
          end
        end
      end
      S_SCL: begin
        dpot_d  = scale(row_q.potential,  pr_q[0]);
        dada_d  = scale(row_q.adaptation, pr_q[1]);
        dbias_d = scale(row_q.homeo_bias, pr_q[2]);
        state_d = S_EVAL;
      end
      S_EVAL: begin
        ram_we = 1'b1;
        wrow.potential        = pot_new;
        wrow.adaptation       = spike ? sat32(ada_sum) : dada_q;
        wrow.homeo_bias       = spike ? sat32(bias_sum) : dbias_q;
        wrow.last_update_time = item_q.tick_time;
        wrow.refractory_end   = spike ? refr_new : row_q.refractory_end;
        wrow.spike_counter    = spike ? cnt_new : row_q.spike_counter;
        pend_d.spiked          = spike;
        pend_d.refractory_hold = hold;
        pend_d.potential_after = pot_new;
        pend_d.spike_total     = spike ? cnt_new : row_q.spike_counter;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!res_valid_q || out_o.ready) begin
          res_d       = pend_q;
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    row_q   <= row_d;
    dt_q    <= dt_d;
    pr_q    <= pr_d;
    pb_q    <= pb_d;
    dpot_q  <= dpot_d;
    dada_q  <= dada_d;
    dbias_q <= dbias_d;
    pend_q  <= pend_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.neuron_out      = res_q.neuron_out;
  assign out_o.spiked          = res_q.spiked;
  assign out_o.refractory_hold = res_q.refractory_hold;
  assign out_o.time_error      = res_q.time_error;
  assign out_o.potential_after = res_q.potential_after;
  assign out_o.spike_total     = res_q.spike_total;

endmodule

`default_nettype wire

### sv/adaptive_lif_neuron_update.sv
// Flow from input accept to valid result: an init or out-of-range item goes to the
//   finish state; a delivery with backwards time reads state, then finishes; other
//   deliveries read, run one square-and-multiply step per bit up to the highest set
//   bit of the clamped elapsed time (at most DT_BITS), then scale, evaluate, finish.
// Throughput: one item per sequencer pass; a two-entry queue and the result
//   register let input and output stall independently.
// ----------------------------------------------------------------------------
// adaptive_lif_neuron_update
// Adaptive leaky integrate-and-fire neuron table update engine. Reset sets control
// and config registers to reset values only; neuron state RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_lif_neuron_update import alf_pkg::*; #(
  parameter int unsigned NEURONS = NEURONS_DEF,
  parameter int unsigned DT_BITS = DT_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  alf_in_if.sink                     in_i,
  alf_out_if.source                  out_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  q_valid, q_pop;
  item_t q_item;
  logic [2:0] outstanding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.membrane_decay    <= MEMBRANE_DECAY_RST;
      cfg_q.adaptation_decay  <= ADAPTATION_DECAY_RST;
      cfg_q.homeostasis_decay <= HOMEOSTASIS_DECAY_RST;
      cfg_q.refractory_ticks  <= '0;
      cfg_q.reset_level       <= '0;
      cfg_q.adaptation_step   <= '0;
      cfg_q.homeostasis_step  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MEMBRANE_DECAY:    cfg_q.membrane_decay    <= cfg_data_i[15:0];
        CFG_ADAPTATION_DECAY:  cfg_q.adaptation_decay  <= cfg_data_i[15:0];
        CFG_HOMEOSTASIS_DECAY: cfg_q.homeostasis_decay <= cfg_data_i[15:0];
        CFG_REFRACTORY_TICKS:  cfg_q.refractory_ticks  <= cfg_data_i[15:0];
        CFG_RESET_LEVEL:       cfg_q.reset_level       <= cfg_data_i;
        CFG_ADAPTATION_STEP:   cfg_q.adaptation_step   <= cfg_data_i;
        CFG_HOMEOSTASIS_STEP:  cfg_q.homeostasis_step  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  alf_front #(
    .NEURONS (NEURONS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  alf_back #(
    .NEURONS (NEURONS),
    .DT_BITS (DT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

  // items in flight: queue, sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      outstanding_q <= outstanding_q + 3'(in_i.valid && in_i.ready)
                       - 3'(out_o.valid && out_o.ready);
    end
  end

  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd4)
    else $error("more items in flight than storage holds");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q == 3'd0 |-> !out_o.valid)
    else $error("result shown with no item in flight");

  a_spike_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.spiked |-> out_o.potential_after == cfg_q.reset_level)
    else $error("spiking neuron not returned to reset level");

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the adaptive LIF neuron update engine. Drives init and delivery
// items over valid/ready with random gaps and stalls, and predicts every result
// from an in-bench model of the neuron table. Each result is checked field by
// field against that prediction. Register settings change between phases while
// the block is idle.
// ----------------------------------------------------------------------------

module tb_top import alf_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    logic [9:0]         neuron;
    bit                 spiked;
    bit                 hold;
    bit                 terr;
    logic signed [31:0] potential;
    logic [15:0]        count;
  } update_t;

  class neuron_scoreboard;
    cfg_t               cfg;
    logic signed [31:0] pot_m   [1024];
    logic signed [31:0] thr_m   [1024];
    logic signed [31:0] adapt_m [1024];
    logic signed [31:0] bias_m  [1024];
    logic [31:0]        last_t  [1024];
    logic [31:0]        refr_end[1024];
    logic [15:0]        spikes  [1024];
    bit                 live    [1024];
    update_t            expected_q[$];
    int                 errors;

    function new();
      cfg = '0;
      cfg.membrane_decay    = MEMBRANE_DECAY_RST;
      cfg.adaptation_decay  = ADAPTATION_DECAY_RST;
      cfg.homeostasis_decay = HOMEOSTASIS_DECAY_RST;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        CFG_MEMBRANE_DECAY:    cfg.membrane_decay    = d[15:0];
        CFG_ADAPTATION_DECAY:  cfg.adaptation_decay  = d[15:0];
        CFG_HOMEOSTASIS_DECAY: cfg.homeostasis_decay = d[15:0];
        CFG_REFRACTORY_TICKS:  cfg.refractory_ticks  = d[15:0];
        CFG_RESET_LEVEL:       cfg.reset_level       = d;
        CFG_ADAPTATION_STEP:   cfg.adaptation_step   = d;
        CFG_HOMEOSTASIS_STEP:  cfg.homeostasis_step  = d[30:0];
        default: ;
      endcase
    endfunction

    // factor^dt in Q1.16 (Q0.16 factor), square-and-multiply over 16 bits with rounding
    function longint unsigned decay_power(logic [15:0] factor, longint unsigned dt);
      longint unsigned r, b;
      r = 65536;
      b = factor;
      for (int i = 0; i < 16; i++) begin
        if (dt[i]) r = (r * b + 32768) >> 16;
        b = (b * b + 32768) >> 16;
      end
      return r;
    endfunction

    function longint decay_value(longint v, longint unsigned p);
      longint unsigned mag;
      longint unsigned m;
      mag = (v < 0) ? -v : v;
      m = (mag * p + 32768) >> 16;
      return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void note(bit kind, logic [9:0] n, logic [31:0] t, logic signed [31:0] val);
      update_t         u;
      longint unsigned dt;
      longint          pot, limit, rend;
      u = '{neuron: n, spiked: 0, hold: 0, terr: 0, potential: 0, count: 0};
      if (kind) begin
        pot_m[n]    = cfg.reset_level;
        thr_m[n]    = val;
        adapt_m[n]  = 0;
        bias_m[n]   = 0;
        last_t[n]   = t;
        refr_end[n] = t;
        spikes[n]   = 0;
        live[n]     = 1;
      end else if (t < last_t[n]) begin
        u.terr = 1;
      end else begin
        dt = 64'(t - last_t[n]);
        if (dt > 65535) dt = 65535;
        pot = decay_value(pot_m[n], decay_power(cfg.membrane_decay, dt));
        adapt_m[n] = 32'(decay_value(adapt_m[n], decay_power(cfg.adaptation_decay, dt)));
        bias_m[n]  = 32'(decay_value(bias_m[n], decay_power(cfg.homeostasis_decay, dt)));
        last_t[n]  = t;
        if (t < refr_end[n]) begin
          u.hold = 1;
          pot = cfg.reset_level;
        end else begin
          pot = clamp32(pot + longint'(val));
          limit = longint'(thr_m[n]) + longint'(adapt_m[n]) + longint'(bias_m[n]);
          if (pot >= limit) begin
            u.spiked = 1;
            if (spikes[n] != 16'hFFFF) spikes[n]++;
            pot = cfg.reset_level;
            adapt_m[n] = 32'(clamp32(longint'(adapt_m[n]) + longint'(cfg.adaptation_step)));
            bias_m[n]  = 32'(clamp32(longint'(bias_m[n]) +
                                     longint'({1'b0, cfg.homeostasis_step})));
            rend = longint'({32'd0, t}) + longint'(cfg.refractory_ticks);
            refr_end[n] = (rend > 64'sh0FFFFFFFF) ? 32'hFFFFFFFF : rend[31:0];
          end
        end
        pot_m[n] = pot[31:0];
      end
      u.potential = pot_m[n];
      u.count     = spikes[n];
      expected_q.insert(expected_q.size(), u);
    endfunction

    function void compare(string field, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, e, a);
      end
    endfunction

    function void check(update_t got);
      update_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result for neuron %0d, expected none actual %0h",
                 $time, got.neuron, got.potential);
        return;
      end
      e = expected_q.pop_front();
      compare("neuron_out", e.neuron, got.neuron);
      compare("spiked", e.spiked, got.spiked);
      compare("refractory_hold", e.hold, got.hold);
      compare("time_error", e.terr, got.terr);
      compare("potential_after", e.potential, got.potential);
      compare("spike_total", e.count, got.count);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  alf_in_if  in_if();
  alf_out_if out_if();

  neuron_scoreboard sb = new();
  bit               calm;
  int               quiet_cycles = 0;
  logic [9:0]       pool[8];

  initial begin
    in_if.valid = 1'b0;
    in_if.kind = 1'b0;
    in_if.neuron = '0;
    in_if.tick_time = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  adaptive_lif_neuron_update dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // result side: check on accept, then stall ready for a random count
  initial begin : result_side
    int stall;
    update_t got;
    stall = 0;
    @(posedge clk_i iff rst_ni);
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        got = '{neuron: out_if.neuron_out, spiked: out_if.spiked,
                hold: out_if.refractory_hold, terr: out_if.time_error,
                potential: out_if.potential_after, count: out_if.spike_total};
        sb.check(got);
        stall = calm ? 0 : $urandom_range(0, 5);
        if (stall > 0) out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        if (stall == 0) out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("adaptive_lif_neuron_update test failed");
      $finish;
    end
  end

  // returns at the accepting edge with valid still high; a next call with a gap or
  // stop_items lowers it, so valid never toggles twice in one step
  task automatic send(bit kind, logic [9:0] n, logic [31:0] t, logic signed [31:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.kind      <= kind;
    in_if.neuron    <= n;
    in_if.tick_time <= t;
    in_if.value     <= val;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note(kind, n, t, val);
  endtask

  task automatic stop_items();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [31:0] md, logic [31:0] ad, logic [31:0] hd,
                            logic [31:0] rt, logic [31:0] rl, logic [31:0] as,
                            logic [31:0] hs);
    logic [31:0] vals[7];
    vals = '{md, ad, hd, rt, rl, as, hs};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_item();
    logic [9:0]         n;
    logic [31:0]        t, last;
    logic signed [31:0] val;
    int                 pick;
    n = pool[$urandom_range(0, 7)];
    if (!sb.live[n] || $urandom_range(0, 99) < 5) begin
      t = ($urandom_range(0, 3) == 0) ? $urandom() : (sb.live[n] ? sb.last_t[n] : 0);
      val = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 4) * 65536;
      send(1'b1, n, t, val);
      return;
    end
    last = sb.last_t[n];
    pick = $urandom_range(0, 99);
    if (pick < 65)      t = last + $urandom_range(0, 8);
    else if (pick < 88) t = last + $urandom_range(0, 300);
    else if (pick < 94) t = last + $urandom_range(60000, 70000);
    else                t = last - $urandom_range(1, 100);
    pick = $urandom_range(0, 99);
    if (pick < 70)      val = $urandom_range(0, 3 * 65536);
    else if (pick < 85) val = -$signed($urandom_range(0, 2 * 65536));
    else                val = $urandom();
    send(1'b0, n, t, val);
  endtask

  initial begin : stimulus
    logic [31:0] rl, as;
    calm = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: overflow, saturated elapsed time, backwards time
    send(1'b1, 10'd0, 32'd0, 32'sd65536);
    send(1'b0, 10'd0, 32'd0, 32'sh7FFFFFFF);
    send(1'b0, 10'd0, 32'd5, 32'sh80000000);
    send(1'b0, 10'd0, 32'd100000, 32'sd65536);
    send(1'b1, 10'd1023, 32'hFFFFFF00, 32'sh80000000);
    send(1'b0, 10'd1023, 32'hFFFFFFFF, 32'sd0);
    send(1'b0, 10'd1023, 32'h00000100, 32'sd7);
    send(1'b0, 10'd0, 32'd100001, 32'sh80000000);
    stop_items();

    // maximum settings: long refractory saturating at end of time
    write_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF);
    send(1'b1, 10'd1023, 32'hFFFFFFF0, 32'sh80000000);
    send(1'b0, 10'd1023, 32'hFFFFFFF0, 32'sd0);
    send(1'b0, 10'd1023, 32'hFFFFFFF8, 32'sd65536);
    send(1'b0, 10'd1023, 32'hFFFFFFFF, 32'sd0);
    send(1'b0, 10'd1023, 32'hFFFFFFFF, 32'sd0);
    send(1'b1, 10'd512, 32'd10, 32'sh7FFFFFFF);
    send(1'b0, 10'd512, 32'd10, 32'sh7FFFFFFF);
    send(1'b0, 10'd512, 32'd11, 32'sd65536);
    send(1'b1, 10'd341, 32'hAAAAAAAA, 32'sh55555555);
    send(1'b0, 10'd341, 32'hAAAAAAAB, 32'shAAAAAAAA);
    stop_items();

    // minimum settings
    write_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h0);
    send(1'b1, 10'd682, 32'h55555555, 32'sd0);
    send(1'b0, 10'd682, 32'h55555556, 32'sd65536);
    send(1'b0, 10'd682, 32'h55555600, 32'sh80000000);
    stop_items();

    for (int phase = 0; phase < 8; phase++) begin
      calm = (phase % 3 == 2);
      for (int i = 0; i < 8; i++) pool[i] = 10'($urandom());
      pool[0] = (phase % 2) ? 10'd1023 : 10'd0;
      if (phase == 6) begin
        write_regs(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF);
      end else if (phase == 7) begin
        write_regs(32'h0, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h0);
      end else begin
        rl = $signed($urandom_range(0, 65536)) - 32'sd32768;
        as = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 65536);
        write_regs($urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(60000, 65535),
                   $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(60000, 65535),
                   $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(60000, 65535),
                   $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 20),
                   rl, as,
                   $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 32768));
      end
      for (int i = 0; i < 150; i++) random_item();
      stop_items();
    end

    if (sb.errors == 0) begin
      $display("adaptive_lif_neuron_update test passed");
    end else begin
      $display("adaptive_lif_neuron_update test failed");
    end
    $finish;
  end

endmodule
